### hw/rtl/cpd_pkg.sv
// Shared types, widths and helpers for the convex polygon pick distance block.
// No dependencies; imported by every module of the block.
package cpd_pkg;

  // Field and datapath widths
  localparam int CoordW   = 16;            // Q12.4 coordinate / Q1.14 depth
  localparam int VtxW     = 3 * CoordW;    // {z, y, x}
  localparam int DiffW    = CoordW + 1;    // coordinate difference
  localparam int AccW     = 36;            // sum of two 17x17 products
  localparam int MulW     = 35;            // serial multiplier operand
  localparam int ProdW    = 2 * MulW;      // serial product / dividend
  localparam int DivW     = 37;            // serial divisor
  localparam int NumW     = 56;            // depth numerator
  localparam int DistW    = 34;            // internal squared distance
  localparam int OutDistW = 33;            // reported squared distance

  localparam int MaxVertsDef = 16;

  localparam logic [OutDistW-1:0] DistMax = '1;
  localparam logic [DistW-1:0]    DistAllOnes = '1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PICK_X = 1'b0,
    CFG_PICK_Y = 1'b1
  } cfg_idx_e;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [CoordW-1:0] vtx_x(logic [VtxW-1:0] v);
    return v[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] vtx_y(logic [VtxW-1:0] v);
    return v[2*CoordW-1:CoordW];
  endfunction

  function automatic logic [CoordW-1:0] vtx_z(logic [VtxW-1:0] v);
    return v[3*CoordW-1:2*CoordW];
  endfunction

  // a - b on signed 16-bit values, full 17-bit result
  function automatic logic signed [DiffW-1:0] sdiff(logic [CoordW-1:0] a,
                                                    logic [CoordW-1:0] b);
    return DiffW'(signed'(a)) - DiffW'(signed'(b));
  endfunction

  // magnitude of an accumulator value (known to fit the multiplier operand)
  function automatic logic [MulW-1:0] acc_mag(logic signed [AccW-1:0] v);
    logic [AccW-1:0] t;
    t = v[AccW-1] ? AccW'(-v) : AccW'(v);
    return t[MulW-1:0];
  endfunction

endpackage

### hw/rtl/cpd_vmem.sv
// Vertex store: one write port, one read port, registered read data.
// Depends on cpd_pkg for the vertex word width.
module cpd_vmem #(
  parameter int DEPTH = cpd_pkg::MaxVertsDef
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [$clog2(DEPTH)-1:0]             waddr_i,
  input  logic [cpd_pkg::VtxW-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0]             raddr_i,
  output logic [cpd_pkg::VtxW-1:0]             rdata_o
);
  import cpd_pkg::*;

  logic [VtxW-1:0] mem [DEPTH];
  logic [VtxW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/cpd_smul.sv
// Serial shift-add multiplier, one operand bit per cycle.
// Depends on cpd_pkg for widths and the unit status struct.
module cpd_smul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cpd_pkg::MulW-1:0]    a_i,
  input  logic [cpd_pkg::MulW-1:0]    b_i,
  output logic [cpd_pkg::ProdW-1:0]   prod_o,
  output cpd_pkg::unit_stat_t         stat_o
);
  import cpd_pkg::*;

  localparam int CntW = $clog2(MulW + 1);

  logic [ProdW-1:0] acc_q, a_q;
  logic [MulW-1:0]  b_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(MulW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath: add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= ProdW'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hw/rtl/cpd_sdiv.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on cpd_pkg for widths and the unit status struct.
module cpd_sdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cpd_pkg::ProdW-1:0]   dvd_i,
  input  logic [cpd_pkg::DivW-1:0]    dvs_i,
  output logic [cpd_pkg::ProdW-1:0]   quo_o,
  output cpd_pkg::unit_stat_t         stat_o
);
  import cpd_pkg::*;

  localparam int CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0] quo_q;
  logic [DivW:0]    rem_q, rem_s;
  logic [DivW-1:0]  dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(ProdW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift in the next dividend bit, subtract when the divisor fits
  assign rem_s = {rem_q[DivW-1:0], quo_q[ProdW-1]};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dvd_i;
      rem_q <= '0;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      if (rem_s >= {1'b0, dvs_q}) begin
        rem_q <= rem_s - {1'b0, dvs_q};
        quo_q <= {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_q <= rem_s;
        quo_q <= {quo_q[ProdW-2:0], 1'b0};
      end
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  // a divide must never restart while one is running
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");

endmodule

### hw/rtl/convex_polygon_pick_distance_top.sv
// Convex polygon pick distance: top level with the load/walk sequencer.
// Depends on cpd_pkg, cpd_vmem, cpd_smul and cpd_sdiv.
//
// Vertices arrive one per transfer and are written to a vertex memory; each stored
// vertex takes the transfer plus two multiply-accumulate steps that update the
// nearest vertex, vertices past MAX_VERTS take the transfer only. On the last vertex
// of a polygon of n >= 3 vertices the sequencer walks every edge through the single
// memory read port: a setup fetches the first three vertices, then each edge ends
// after its cross product when the pick point is on the inner side, adds dot,
// length and distance steps when the nearest point is an edge end, and when it lies
// on the edge span goes through the shared serial multiplier and the serial divider.
// A point inside adds the depth (three serial products and one serial divide). The
// next polygon is taken once the result is in the output register; a result
// that waits on a stalled output holds off only the next result.
module convex_polygon_pick_distance_top #(
  parameter int MAX_VERTS = cpd_pkg::MaxVertsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [0:0]                            cfg_idx_i,
  input  logic [cpd_pkg::CoordW-1:0]            cfg_wdata_i,
  // vertex input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cpd_pkg::CoordW-1:0]     vertex_x_i,
  input  logic signed [cpd_pkg::CoordW-1:0]     vertex_y_i,
  input  logic signed [cpd_pkg::CoordW-1:0]     vertex_z_i,
  input  logic                                  last_vertex_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [cpd_pkg::OutDistW-1:0]          hit_dist_sq_o,
  output logic signed [cpd_pkg::CoordW-1:0]     hit_depth_o,
  output logic [3:0]                            nearest_vertex_o,
  output logic                                  is_inside_o
);
  import cpd_pkg::*;

  localparam int IW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef enum logic [5:0] {
    S_IDLE, S_LD1, S_LD2, S_START,
    S_R0, S_R1, S_R2, S_R3, S_DP, S_DET1, S_DET2,
    S_E0, S_E1, S_E2, S_C1, S_C2, S_D1, S_D2, S_L1, S_L2,
    S_PD1, S_PD2, S_SQM, S_SQW, S_SQD, S_ENEXT, S_WEND,
    S_N1A, S_N1B, S_N2A, S_N2B, S_MS, S_MW, S_DVS, S_DVW, S_FIN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [CoordW-1:0] pick_x_q, pick_y_q;

  // polygon state
  logic [CW-1:0]    count_q, ei_q, ei_nxt;
  logic [IW-1:0]    idx_q, nidx_q;
  logic [DistW-1:0] near_q, best_q;
  logic             last_q, inside_q, sel_u_q, neg_q;
  logic [1:0]       k_q;
  logic             tsign_q;

  // datapath registers
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic signed [DiffW-1:0] ex_q, ey_q, wx_q, wy_q, ux_q, uy_q;
  logic signed [DiffW-1:0] ax_q, ay_q, bx_q, by_q, px_q, py_q, dz1_q, dz2_q;
  logic [VtxW-1:0]         v0_q, v1_q, ra_q;
  logic signed [AccW-1:0]  acc_q, det_q, cr_q, dot_q, len_q, n1_q, n2_q;
  logic signed [NumW-1:0]  num_q;
  logic signed [CoordW-1:0] depth_q;

  // output register
  logic                 out_valid_q, inside_out_q;
  logic [OutDistW-1:0]  dist_out_q;
  logic [CoordW-1:0]    depth_out_q;
  logic [IW-1:0]        nidx_out_q;

  // memory and arithmetic unit hookup
  logic                 mem_we;
  logic [IW-1:0]        mem_raddr;
  logic [VtxW-1:0]      mem_rdata;
  logic                 mul_start, div_start;
  logic [MulW-1:0]      mul_a, mul_b;
  logic [ProdW-1:0]     mul_prod, div_dvd, div_quo;
  logic [DivW-1:0]      div_dvs;
  unit_stat_t           mul_stat, div_stat;

  logic in_xfer;
  assign in_xfer    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign mem_we     = in_xfer && (count_q < CW'(MAX_VERTS));
  assign ei_nxt     = (ei_q + 1'b1 < count_q) ? ei_q + 1'b1 : '0;

  cpd_vmem #(.DEPTH(MAX_VERTS)) u_vmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i ({vertex_z_i, vertex_y_i, vertex_x_i}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cpd_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .stat_o  (mul_stat)
  );

  cpd_sdiv u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // read address by sequencer step
  always_comb begin
    unique case (state_q)
      S_R2:    mem_raddr = IW'(1);
      S_R3:    mem_raddr = IW'(2);
      S_E0:    mem_raddr = ei_q[IW-1:0];
      S_E1:    mem_raddr = ei_nxt[IW-1:0];
      default: mem_raddr = '0;
    endcase
  end

  // shared 17x17 multiply-accumulate
  logic signed [DiffW-1:0]   ma, mb;
  logic signed [2*DiffW-1:0] mprod;
  logic signed [AccW-1:0]    mac_res;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_LD1:   begin ma = dx_q; mb = dx_q; end
      S_LD2:   begin ma = dy_q; mb = dy_q; end
      S_DET1:  begin ma = ax_q; mb = by_q; end
      S_DET2:  begin ma = ay_q; mb = bx_q; end
      S_C1:    begin ma = ex_q; mb = wy_q; end
      S_C2:    begin ma = ey_q; mb = wx_q; end
      S_D1:    begin ma = ex_q; mb = wx_q; end
      S_D2:    begin ma = ey_q; mb = wy_q; end
      S_L1:    begin ma = ex_q; mb = ex_q; end
      S_L2:    begin ma = ey_q; mb = ey_q; end
      S_PD1:   begin ma = sel_u_q ? ux_q : wx_q; mb = ma; end
      S_PD2:   begin ma = sel_u_q ? uy_q : wy_q; mb = ma; end
      S_N1A:   begin ma = px_q; mb = by_q; end
      S_N1B:   begin ma = py_q; mb = bx_q; end
      S_N2A:   begin ma = ax_q; mb = py_q; end
      S_N2B:   begin ma = ay_q; mb = px_q; end
      default: begin ma = '0; mb = '0; end
    endcase
    mprod = ma * mb;
    unique case (state_q)
      S_LD1, S_DET1, S_C1, S_D1, S_L1, S_PD1, S_N1A, S_N2A:
        mac_res = AccW'(mprod);
      S_LD2, S_D2, S_L2, S_PD2:
        mac_res = acc_q + AccW'(mprod);
      S_DET2, S_C2, S_N1B, S_N2B:
        mac_res = acc_q - AccW'(mprod);
      default:
        mac_res = acc_q;
    endcase
  end

  // serial unit operands
  logic [MulW-1:0] det_mag;
  logic [NumW-1:0] num_mag;
  assign det_mag = acc_mag(det_q);
  assign num_mag = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_q)
      S_SQM: begin
        mul_start = 1'b1;
        mul_a     = acc_mag(cr_q);
        mul_b     = acc_mag(cr_q);
      end
      S_SQW: begin
        div_start = mul_stat.done;
        div_dvd   = mul_prod;
        div_dvs   = DivW'(len_q);
      end
      S_MS: begin
        mul_start = 1'b1;
        unique case (k_q)
          2'd0:    begin mul_a = det_mag;          mul_b = MulW'(acc_mag(AccW'(signed'(vtx_z(v0_q))))); end
          2'd1:    begin mul_a = acc_mag(n1_q);    mul_b = acc_mag(AccW'(dz1_q)); end
          default: begin mul_a = acc_mag(n2_q);    mul_b = acc_mag(AccW'(dz2_q)); end
        endcase
      end
      S_DVS: begin
        div_start = 1'b1;
        div_dvd   = ProdW'({num_mag, 1'b0}) + ProdW'(det_mag);
        div_dvs   = DivW'({det_mag, 1'b0});
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // signed value of the finished product term
  logic signed [NumW-1:0] term;
  assign term = tsign_q ? -signed'(mul_prod[NumW-1:0]) : signed'(mul_prod[NumW-1:0]);

  // squared distance from an interior edge span, clamped
  logic [DistW-1:0] span_d;
  assign span_d = (div_quo[ProdW-1:DistW] != '0) ? DistAllOnes : div_quo[DistW-1:0];

  // rounded depth, saturated to 16 bits
  logic [CoordW-1:0] depth_sat;
  always_comb begin
    if (neg_q) begin
      depth_sat = (div_quo > ProdW'(32768)) ? 16'h8000 : CoordW'(-div_quo[CoordW-1:0]);
    end else begin
      depth_sat = (div_quo > ProdW'(32767)) ? 16'h7FFF : div_quo[CoordW-1:0];
    end
  end

  // edge endpoints, swapped for clockwise winding
  logic [VtxW-1:0] ep, eq;
  assign ep = det_q[AccW-1] ? mem_rdata : ra_q;
  assign eq = det_q[AccW-1] ? ra_q : mem_rdata;

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pick_x_q     <= '0;
      pick_y_q     <= '0;
      count_q      <= '0;
      ei_q         <= '0;
      idx_q        <= '0;
      nidx_q       <= '0;
      near_q       <= DistAllOnes;
      best_q       <= DistAllOnes;
      last_q       <= 1'b0;
      inside_q     <= 1'b1;
      sel_u_q      <= 1'b0;
      neg_q        <= 1'b0;
      k_q          <= '0;
      tsign_q      <= 1'b0;
      dx_q <= '0; dy_q <= '0;
      ex_q <= '0; ey_q <= '0; wx_q <= '0; wy_q <= '0; ux_q <= '0; uy_q <= '0;
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; px_q <= '0; py_q <= '0;
      dz1_q <= '0; dz2_q <= '0;
      v0_q <= '0; v1_q <= '0; ra_q <= '0;
      acc_q <= '0; det_q <= '0; cr_q <= '0; dot_q <= '0; len_q <= '0;
      n1_q <= '0; n2_q <= '0; num_q <= '0; depth_q <= '0;
      out_valid_q  <= 1'b0;
      inside_out_q <= 1'b0;
      dist_out_q   <= '0;
      depth_out_q  <= '0;
      nidx_out_q   <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PICK_X) begin
          pick_x_q <= cfg_wdata_i;
        end else begin
          pick_y_q <= cfg_wdata_i;
        end
      end

      // output transfer frees the register; the finish step reloads it itself
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end

      acc_q <= mac_res;

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            last_q <= last_vertex_i;
            if (count_q < CW'(MAX_VERTS)) begin
              dx_q    <= sdiff(vertex_x_i, pick_x_q);
              dy_q    <= sdiff(vertex_y_i, pick_y_q);
              idx_q   <= count_q[IW-1:0];
              count_q <= count_q + 1'b1;
              state_q <= S_LD1;
            end else if (last_vertex_i) begin
              state_q <= S_START;
            end
          end
        end
        S_LD1: state_q <= S_LD2;
        S_LD2: begin
          // nearest vertex, first one wins ties
          if (mac_res[DistW-1:0] < near_q) begin
            near_q <= mac_res[DistW-1:0];
            nidx_q <= idx_q;
          end
          state_q <= last_q ? S_START : S_IDLE;
        end
        S_START: begin
          ei_q     <= '0;
          best_q   <= DistAllOnes;
          inside_q <= 1'b1;
          if (count_q < CW'(3)) begin
            // short polygon: no result
            count_q <= '0;
            near_q  <= DistAllOnes;
            nidx_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_R0;
          end
        end
        // fetch the first three vertices
        S_R0: state_q <= S_R1;
        S_R1: state_q <= S_R2;
        S_R2: begin
          v0_q    <= mem_rdata;
          state_q <= S_R3;
        end
        S_R3: begin
          v1_q    <= mem_rdata;
          state_q <= S_DP;
        end
        S_DP: begin
          ax_q    <= sdiff(vtx_x(v1_q), vtx_x(v0_q));
          ay_q    <= sdiff(vtx_y(v1_q), vtx_y(v0_q));
          bx_q    <= sdiff(vtx_x(mem_rdata), vtx_x(v0_q));
          by_q    <= sdiff(vtx_y(mem_rdata), vtx_y(v0_q));
          px_q    <= sdiff(pick_x_q, vtx_x(v0_q));
          py_q    <= sdiff(pick_y_q, vtx_y(v0_q));
          dz1_q   <= sdiff(vtx_z(v1_q), vtx_z(v0_q));
          dz2_q   <= sdiff(vtx_z(mem_rdata), vtx_z(v0_q));
          state_q <= S_DET1;
        end
        S_DET1: state_q <= S_DET2;
        S_DET2: begin
          det_q   <= mac_res;
          state_q <= S_E0;
        end
        // edge walk
        S_E0: state_q <= S_E1;
        S_E1: begin
          ra_q    <= mem_rdata;
          state_q <= S_E2;
        end
        S_E2: begin
          ex_q    <= sdiff(vtx_x(eq), vtx_x(ep));
          ey_q    <= sdiff(vtx_y(eq), vtx_y(ep));
          wx_q    <= sdiff(pick_x_q, vtx_x(ep));
          wy_q    <= sdiff(pick_y_q, vtx_y(ep));
          ux_q    <= sdiff(vtx_x(eq), pick_x_q);
          uy_q    <= sdiff(vtx_y(eq), pick_y_q);
          state_q <= S_C1;
        end
        S_C1: state_q <= S_C2;
        S_C2: begin
          cr_q <= mac_res;
          if (mac_res[AccW-1]) begin
            inside_q <= 1'b0;
            state_q  <= S_D1;
          end else begin
            state_q  <= S_ENEXT;
          end
        end
        S_D1: state_q <= S_D2;
        S_D2: begin
          dot_q   <= mac_res;
          state_q <= S_L1;
        end
        S_L1: state_q <= S_L2;
        S_L2: begin
          len_q <= mac_res;
          if (dot_q[AccW-1]) begin
            sel_u_q <= 1'b0;
            state_q <= S_PD1;
          end else if (dot_q > mac_res) begin
            sel_u_q <= 1'b1;
            state_q <= S_PD1;
          end else begin
            state_q <= S_SQM;
          end
        end
        S_PD1: state_q <= S_PD2;
        S_PD2: begin
          if (mac_res[DistW-1:0] < best_q) begin
            best_q <= mac_res[DistW-1:0];
          end
          state_q <= S_ENEXT;
        end
        S_SQM: state_q <= S_SQW;
        S_SQW: begin
          if (mul_stat.done) begin
            state_q <= S_SQD;
          end
        end
        S_SQD: begin
          if (div_stat.done) begin
            if (span_d < best_q) begin
              best_q <= span_d;
            end
            state_q <= S_ENEXT;
          end
        end
        S_ENEXT: begin
          ei_q    <= ei_q + 1'b1;
          state_q <= (ei_q + 1'b1 == count_q) ? S_WEND : S_E0;
        end
        S_WEND: begin
          depth_q <= '0;
          num_q   <= '0;
          k_q     <= '0;
          if (inside_q && (det_q != '0)) begin
            state_q <= S_N1A;
          end else begin
            state_q <= S_FIN;
          end
        end
        // depth over the plane of the first three vertices
        S_N1A: state_q <= S_N1B;
        S_N1B: begin
          n1_q    <= mac_res;
          state_q <= S_N2A;
        end
        S_N2A: state_q <= S_N2B;
        S_N2B: begin
          n2_q    <= mac_res;
          state_q <= S_MS;
        end
        S_MS: begin
          unique case (k_q)
            2'd0:    tsign_q <= det_q[AccW-1] ^ v0_q[VtxW-1];
            2'd1:    tsign_q <= n1_q[AccW-1] ^ dz1_q[DiffW-1];
            default: tsign_q <= n2_q[AccW-1] ^ dz2_q[DiffW-1];
          endcase
          state_q <= S_MW;
        end
        S_MW: begin
          if (mul_stat.done) begin
            num_q <= num_q + term;
            if (k_q == 2'd2) begin
              state_q <= S_DVS;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_MS;
            end
          end
        end
        S_DVS: begin
          neg_q   <= num_q[NumW-1] ^ det_q[AccW-1];
          state_q <= S_DVW;
        end
        S_DVW: begin
          if (div_stat.done) begin
            depth_q <= signed'(depth_sat);
            state_q <= S_FIN;
          end
        end
        // load the result once the output register is free
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            inside_out_q <= inside_q;
            dist_out_q   <= inside_q ? '0 :
                            (best_q[DistW-1] ? DistMax : best_q[OutDistW-1:0]);
            depth_out_q  <= inside_q ? depth_q : '0;
            nidx_out_q   <= nidx_q;
            count_q      <= '0;
            near_q       <= DistAllOnes;
            nidx_q       <= '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // outputs
  logic [IW+3:0] nidx_ext;
  assign nidx_ext         = (IW + 4)'(nidx_out_q);
  assign out_valid_o      = out_valid_q;
  assign hit_dist_sq_o    = dist_out_q;
  assign hit_depth_o      = signed'(depth_out_q);
  assign nearest_vertex_o = nidx_ext[3:0];
  assign is_inside_o      = inside_out_q;

  // assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTS)) else $error("vertex count past capacity");

  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E0) |-> (ei_q < count_q)) else $error("edge index past count");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_FIN))
    else $error("result loaded outside the finish step");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && inside_out_q) |-> (dist_out_q == '0))
    else $error("inside result with nonzero distance");

endmodule
